### src/mwp_pkg.sv
package mwp_pkg;

    localparam int PIXEL_COUNT_LOG2_DEF = 24;
    localparam int PEL_WIDTH_DEF = 16;
    localparam int BPP_W = 5;
    localparam logic [BPP_W-1:0] BPP_RESET = 5'd8;
    localparam int PSNR_W = 16;
    localparam int LOG_W = 22;
    localparam logic [31:0] TEN_LOG10_2_Q24 = 32'd50504453;
    localparam logic [PSNR_W-1:0] ZERO_ERR_PSNR = 16'd25600;

    localparam logic [1:0] LOG_SEL_PEAK = 2'd0;
    localparam logic [1:0] LOG_SEL_TOT = 2'd1;
    localparam logic [1:0] LOG_SEL_SSE = 2'd2;

    typedef struct packed {
        logic clear;
        logic start;
        logic div_step;
        logic log_load;
        logic log_step;
        logic [1:0] log_sel;
        logic fin;
    } cmd_t;

endpackage

### src/masked_weighted_psnr.sv
// channel | dir | handshake          | payload
// cfg     | in  | cfg_valid/ready    | cfg_data (bits_per_pel)
// pixel   | in  | in_valid/in_ready  | mask_weight, rec_pel, org_pel, last
// result  | out | out_valid/ready    | psnr_q8, wmse_q8, weighted_sse, weight_total,
//         |     |                    | sse_saturated
// one pixel per cycle; a last pixel holds off input while the block drains the
// multiply pipe, takes 72 steps of the serial divider, makes three squaring log2
// runs and assembles the result, which shows on the outputs the cycle after
// reset clears accumulators and sets bit depth to 8
// a waiting result holds off new requests until it is taken
module masked_weighted_psnr #(
    parameter int PIXEL_COUNT_LOG2 = mwp_pkg::PIXEL_COUNT_LOG2_DEF,
    parameter int PEL_WIDTH = mwp_pkg::PEL_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [4:0] cfg_data,
    input  logic in_valid,
    output logic in_ready,
    input  logic [15:0] mask_weight,
    input  logic [15:0] rec_pel,
    input  logic [15:0] org_pel,
    input  logic last,
    output logic out_valid,
    input  logic out_ready,
    output logic [15:0] psnr_q8,
    output logic [39:0] wmse_q8,
    output logic [63:0] weighted_sse,
    output logic [39:0] weight_total,
    output logic sse_saturated
);
    logic [4:0] bpp_reg;
    mwp_pkg::cmd_t cmd;
    logic in_fire;

    assign cfg_ready = 1'b1;
    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bpp_reg <= mwp_pkg::BPP_RESET;
        else if (cfg_valid)
            bpp_reg <= cfg_data;
    end

    mwp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_last(last),
        .out_fire(out_valid && out_ready), .in_ready(in_ready),
        .out_valid(out_valid), .cmd(cmd)
    );

    mwp_datapath #(.PIXEL_COUNT_LOG2(PIXEL_COUNT_LOG2), .PEL_WIDTH(PEL_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .acc_en(in_fire), .mask_weight(mask_weight),
        .rec_pel(rec_pel), .org_pel(org_pel), .bits_per_pel(bpp_reg), .cmd(cmd),
        .psnr_q8(psnr_q8), .wmse_q8(wmse_q8), .weighted_sse(weighted_sse),
        .weight_total(weight_total), .sse_saturated(sse_saturated)
    );

endmodule

### src/mwp_datapath.sv
module mwp_datapath #(
    parameter int PIXEL_COUNT_LOG2 = mwp_pkg::PIXEL_COUNT_LOG2_DEF,
    parameter int PEL_WIDTH = mwp_pkg::PEL_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic acc_en,
    input  logic [15:0] mask_weight,
    input  logic [15:0] rec_pel,
    input  logic [15:0] org_pel,
    input  logic [mwp_pkg::BPP_W-1:0] bits_per_pel,
    input  mwp_pkg::cmd_t cmd,
    output logic [15:0] psnr_q8,
    output logic [39:0] wmse_q8,
    output logic [63:0] weighted_sse,
    output logic [39:0] weight_total,
    output logic sse_saturated
);
    localparam int WT_W = PIXEL_COUNT_LOG2 + 16;
    localparam logic [WT_W-1:0] WT_MAX = {WT_W{1'b1}};

    // pixel product stage
    logic [PEL_WIDTH-1:0] rec_m, org_m, diff;
    logic [2*PEL_WIDTH-1:0] sq_reg, sq_next;
    logic [15:0] w_reg;
    logic pv_reg;
    logic [63:0] prod_reg;
    logic pp_reg;
    logic [63:0] sse_reg, sse_next;
    logic [WT_W-1:0] wt_reg, wt_next;
    logic [WT_W:0] wt_sum;
    logic [64:0] sse_sum;
    logic sat_reg, sat_next;

    assign rec_m = rec_pel[PEL_WIDTH-1:0];
    assign org_m = org_pel[PEL_WIDTH-1:0];
    assign diff = (rec_m >= org_m) ? rec_m - org_m : org_m - rec_m;
    assign sq_next = diff * diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            pp_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= acc_en;
            pp_reg <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
        w_reg <= mask_weight;
        prod_reg <= 64'(sq_reg) * 64'(w_reg);
    end

    assign sse_sum = {1'b0, sse_reg} + {1'b0, prod_reg};
    always_comb
    begin
        sse_next = sse_reg;
        sat_next = sat_reg;
        wt_next = wt_reg;
        if (cmd.clear)
        begin
            sse_next = '0;
            sat_next = 1'b0;
            wt_next = '0;
        end
        else
        begin
            if (pp_reg)
            begin
                if (sse_sum[64])
                begin
                    sse_next = '1;
                    sat_next = 1'b1;
                end
                else
                    sse_next = sse_sum[63:0];
            end
            if (acc_en)
                wt_next = wt_sum[WT_W] ? WT_MAX : wt_sum[WT_W-1:0];
        end
    end
    assign wt_sum = {1'b0, wt_reg} + {{(WT_W-16){1'b0}}, 1'b0, mask_weight};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sse_reg <= '0;
            wt_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            sse_reg <= sse_next;
            wt_reg <= wt_next;
            sat_reg <= sat_next;
        end
    end

    // frame-end snapshot
    logic [63:0] fs_reg;
    logic [39:0] ft_reg;
    logic fsat_reg;
    logic [4:0] bits;
    logic [31:0] pk2;
    logic [31:0] pk2_reg;

    always_comb
    begin
        bits = bits_per_pel;
        if (bits == 5'd0)
            bits = 5'd1;
        if (bits > 5'(PEL_WIDTH))
            bits = 5'(PEL_WIDTH);
    end
    assign pk2 = (32'(1) << {bits, 1'b0}) - (32'(1) << (bits + 5'd1)) + 32'd1;

    // restoring divider: (sse << 8) / tot, 72 quotient bits
    logic [71:0] dq_reg;
    logic [40:0] dr_reg;
    logic [41:0] dtry;
    logic [40:0] dsh;

    assign dsh = {dr_reg[39:0], dq_reg[71]};
    assign dtry = {1'b0, dsh} - {2'b00, ft_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            fs_reg <= sse_reg;
            ft_reg <= 40'(wt_reg);
            fsat_reg <= sat_reg;
            pk2_reg <= pk2;
            dq_reg <= {sse_reg, 8'd0};
            dr_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!dtry[41])
            begin
                dr_reg <= dtry[40:0];
                dq_reg <= {dq_reg[70:0], 1'b1};
            end
            else
            begin
                dr_reg <= dsh;
                dq_reg <= {dq_reg[70:0], 1'b0};
            end
        end
    end

    // iterative log2 in Q.16
    logic [63:0] lsrc;
    logic [5:0] lead;
    logic [30:0] ly_reg;
    logic [15:0] lf_reg;
    logic [5:0] ln_reg;
    logic [61:0] lsq;
    logic [mwp_pkg::LOG_W-1:0] lg_res;
    logic [mwp_pkg::LOG_W-1:0] lgp_reg, lgt_reg;
    logic [127:0] lnorm;

    always_comb
    begin
        unique case (cmd.log_sel)
            mwp_pkg::LOG_SEL_PEAK: lsrc = 64'(pk2_reg);
            mwp_pkg::LOG_SEL_TOT: lsrc = 64'(ft_reg);
            default: lsrc = fs_reg;
        endcase
    end

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 64; i++)
            if (lsrc[i])
                lead = 6'(i);
    end

    assign lnorm = {64'd0, lsrc} << (7'd94 - {1'b0, lead});
    assign lsq = 62'(ly_reg) * 62'(ly_reg);
    assign lg_res = {ln_reg, lf_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.log_load)
        begin
            ln_reg <= lead;
            ly_reg <= lnorm[94:64];
            lf_reg <= '0;
        end
        else if (cmd.log_step)
        begin
            if (lsq[61])
            begin
                ly_reg <= lsq[61:31];
                lf_reg <= {lf_reg[14:0], 1'b1};
            end
            else
            begin
                ly_reg <= lsq[60:30];
                lf_reg <= {lf_reg[14:0], 1'b0};
            end
        end
        if (cmd.log_load && cmd.log_sel == mwp_pkg::LOG_SEL_TOT)
            lgp_reg <= lg_res;
        if (cmd.log_load && cmd.log_sel == mwp_pkg::LOG_SEL_SSE)
            lgt_reg <= lg_res;
    end

    // final assembly
    logic signed [mwp_pkg::LOG_W+1:0] dl;
    logic [55:0] pmul;
    logic [31:0] prnd;

    assign dl = $signed({2'b00, lgp_reg}) + $signed({2'b00, lgt_reg})
        - $signed({2'b00, lg_res});
    assign pmul = 56'(dl[mwp_pkg::LOG_W:0]) * 56'(mwp_pkg::TEN_LOG10_2_Q24);
    assign prnd = 32'((pmul + 56'h80000000) >> 32);

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            weighted_sse <= fs_reg;
            weight_total <= ft_reg;
            sse_saturated <= fsat_reg;
            if (fs_reg == 64'd0)
            begin
                wmse_q8 <= '0;
                psnr_q8 <= mwp_pkg::ZERO_ERR_PSNR;
            end
            else if (ft_reg == 40'd0)
            begin
                wmse_q8 <= '1;
                psnr_q8 <= '0;
            end
            else
            begin
                wmse_q8 <= (dq_reg[71:40] != 32'd0) ? '1 : dq_reg[39:0];
                if (dl <= 0)
                    psnr_q8 <= '0;
                else if (prnd > 32'd65535)
                    psnr_q8 <= '1;
                else
                    psnr_q8 <= prnd[15:0];
            end
        end
    end

endmodule

### src/mwp_ctrl.sv
module mwp_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  logic in_last,
    input  logic out_fire,
    output logic in_ready,
    output logic out_valid,
    output mwp_pkg::cmd_t cmd
);
    localparam logic [2:0] S_RUN = 3'd0;
    localparam logic [2:0] S_DRAIN = 3'd1;
    localparam logic [2:0] S_DIV = 3'd2;
    localparam logic [2:0] S_LOG = 3'd3;
    localparam logic [2:0] S_FIN = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [1:0] sel_reg, sel_next;
    logic ov_reg, ov_next;

    assign in_ready = (state_reg == S_RUN) && !ov_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        sel_next = sel_reg;
        ov_next = ov_reg && !out_fire;
        cmd = '0;
        unique case (state_reg)
            S_RUN:
            begin
                if (in_fire && in_last)
                begin
                    state_next = S_DRAIN;
                    cnt_next = 7'd2;
                end
            end
            S_DRAIN:
            begin
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    cmd.start = 1'b1;
                    cmd.clear = 1'b1;
                    state_next = S_DIV;
                    cnt_next = 7'd71;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    state_next = S_LOG;
                    sel_next = mwp_pkg::LOG_SEL_PEAK;
                    cnt_next = 7'd17;
                end
            end
            S_LOG:
            begin
                cmd.log_sel = sel_reg;
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd17)
                    cmd.log_load = 1'b1;
                else if (cnt_reg != 7'd0)
                    cmd.log_step = 1'b1;
                else
                begin
                    cnt_next = 7'd16;
                    if (sel_reg == mwp_pkg::LOG_SEL_SSE)
                        state_next = S_FIN;
                    else
                    begin
                        cmd.log_load = 1'b1;
                        sel_next = sel_reg + 2'd1;
                        cmd.log_sel = sel_reg + 2'd1;
                    end
                end
            end
            S_FIN:
            begin
                if (!ov_reg)
                begin
                    cmd.log_sel = mwp_pkg::LOG_SEL_SSE;
                    cmd.fin = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_RUN;
                end
            end
            default:
                state_next = S_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            cnt_reg <= '0;
            sel_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            sel_reg <= sel_next;
            ov_reg <= ov_next;
        end
    end

endmodule

### src/mwp_checker.sv
module mwp_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic last,
    input logic out_valid,
    input logic out_ready,
    input logic [15:0] psnr_q8,
    input logic [63:0] weighted_sse,
    input logic [39:0] wmse_q8
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(psnr_q8))
        else $error("result changed while stalled");
    a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !in_ready)
        else $error("request taken right after frame end");
    a_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && weighted_sse == 64'd0 |-> psnr_q8 == 16'd25600 && wmse_q8 == 40'd0)
        else $error("zero error result wrong");
endmodule

bind masked_weighted_psnr mwp_checker u_mwp_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .psnr_q8(psnr_q8),
    .weighted_sse(weighted_sse), .wmse_q8(wmse_q8)
);

### tb/masked_weighted_psnr_checker.sv
`timescale 1ns / 1ps

module masked_weighted_psnr_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_valid,
    input  logic cfg_ready,
    input  logic [4:0] cfg_data,
    input  logic in_valid,
    input  logic in_ready,
    input  logic [15:0] mask_weight,
    input  logic [15:0] rec_pel,
    input  logic [15:0] org_pel,
    input  logic last,
    input  logic out_valid,
    input  logic out_ready,
    input  logic [15:0] psnr_q8,
    input  logic [39:0] wmse_q8,
    input  logic [63:0] weighted_sse,
    input  logic [39:0] weight_total,
    input  logic sse_saturated,
    output int errors,
    output int pending
);
    typedef struct packed {
        logic [15:0] psnr;
        logic [39:0] wmse;
        logic [63:0] sse;
        logic [39:0] tot;
        logic sat;
    } frame_stats_t;

    localparam logic [63:0] SSE_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TOT_MAX =
        (64'd1 << (mwp_pkg::PIXEL_COUNT_LOG2_DEF + 16)) - 64'd1;
    localparam logic [63:0] WMSE_MAX = (64'd1 << 40) - 64'd1;

    frame_stats_t frame_results[$];
    logic [63:0] err_sum;
    logic [63:0] wt_sum;
    logic err_sat;
    logic [4:0] depth;

    function automatic logic [63:0] log2_fix(input logic [63:0] x);
        int n;
        logic [63:0] y;
        logic [15:0] frac;
        n = 63;
        frac = '0;
        if (x == 64'd0)
            return 64'd0;
        while (x[n] == 1'b0)
            n--;
        if (n > 30)
            y = x >> (n - 30);
        else
            y = x << (30 - n);
        for (int i = 0; i < 16; i++)
        begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30))
            begin
                y = y >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(n) << 16) | 64'(frac);
    endfunction

    function automatic frame_stats_t frame_psnr(input logic [63:0] sse, input logic [63:0] tot,
                                                input logic sat, input logic [4:0] bpp);
        frame_stats_t r;
        int b;
        logic [63:0] peak, q, rem, wm, ps;
        longint dl;
        b = int'(bpp);
        if (b < 1)
            b = 1;
        if (b > mwp_pkg::PEL_WIDTH_DEF)
            b = mwp_pkg::PEL_WIDTH_DEF;
        peak = (64'd1 << b) - 64'd1;
        if (sse == 64'd0)
        begin
            wm = '0;
            ps = 64'(mwp_pkg::ZERO_ERR_PSNR);
        end
        else if (tot == 64'd0)
        begin
            wm = WMSE_MAX;
            ps = '0;
        end
        else
        begin
            q = sse / tot;
            rem = sse % tot;
            if (q >= (64'd1 << 32))
                wm = WMSE_MAX;
            else
                wm = (q << 8) + (rem << 8) / tot;
            dl = longint'(log2_fix(peak * peak)) + longint'(log2_fix(tot))
                 - longint'(log2_fix(sse));
            if (dl <= 0)
                ps = '0;
            else
            begin
                ps = (64'(dl) * 64'(mwp_pkg::TEN_LOG10_2_Q24) + (64'd1 << 31)) >> 32;
                if (ps > 64'd65535)
                    ps = 64'd65535;
            end
        end
        r.psnr = ps[15:0];
        r.wmse = wm[39:0];
        r.sse = sse;
        r.tot = tot[39:0];
        r.sat = sat;
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] d, p;
        frame_stats_t e;
        if (!rst_n)
        begin
            frame_results.delete();
            err_sum = '0;
            wt_sum = '0;
            err_sat = 1'b0;
            depth = mwp_pkg::BPP_RESET;
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frame_results.size() == 0)
                    report("unexpected result", 64'd1, 64'd0);
                else
                begin
                    e = frame_results.pop_front();
                    if (psnr_q8 !== e.psnr)
                        report("psnr_q8", 64'(psnr_q8), 64'(e.psnr));
                    if (wmse_q8 !== e.wmse)
                        report("wmse_q8", 64'(wmse_q8), 64'(e.wmse));
                    if (weighted_sse !== e.sse)
                        report("weighted_sse", weighted_sse, e.sse);
                    if (weight_total !== e.tot)
                        report("weight_total", 64'(weight_total), 64'(e.tot));
                    if (sse_saturated !== e.sat)
                        report("sse_saturated", 64'(sse_saturated), 64'(e.sat));
                end
            end
            if (cfg_valid && cfg_ready)
                depth = cfg_data;
            if (in_valid && in_ready)
            begin
                d = (rec_pel >= org_pel) ? 64'(rec_pel - org_pel) : 64'(org_pel - rec_pel);
                p = 64'(mask_weight) * d * d;
                if (err_sum > SSE_MAX - p)
                begin
                    err_sum = SSE_MAX;
                    err_sat = 1'b1;
                end
                else
                    err_sum = err_sum + p;
                wt_sum = wt_sum + 64'(mask_weight);
                if (wt_sum > TOT_MAX)
                    wt_sum = TOT_MAX;
                if (last)
                begin
                    frame_results.push_back(frame_psnr(err_sum, wt_sum, err_sat, depth));
                    err_sum = '0;
                    wt_sum = '0;
                    err_sat = 1'b0;
                end
            end
            pending <= frame_results.size();
        end
    end
endmodule

### tb/masked_weighted_psnr_test.sv
`timescale 1ns / 1ps

module masked_weighted_psnr_test;
    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [4:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_ready;
    logic [15:0] mask_weight = 0;
    logic [15:0] rec_pel = 0;
    logic [15:0] org_pel = 0;
    logic last = 0;
    logic out_valid;
    logic out_ready = 0;
    logic [15:0] psnr_q8;
    logic [39:0] wmse_q8;
    logic [63:0] weighted_sse;
    logic [39:0] weight_total;
    logic sse_saturated;
    int errors;
    int pending;
    int send_idle = 0;
    int recv_idle = 0;
    logic hold = 0;
    int quiet = 0;

    localparam int QUIET_LIMIT = 20000;

    always #5 clk = ~clk;

    masked_weighted_psnr DUT (.*);

    masked_weighted_psnr_checker checker_i (.*);

    always @(posedge clk)
        out_ready <= !hold && ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("masked_weighted_psnr_test failed");
            $finish;
        end
    end

    task automatic send_pixel(input logic [15:0] w, input logic [15:0] r,
                              input logic [15:0] o, input logic l);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        mask_weight <= w;
        rec_pel <= r;
        org_pel <= o;
        last <= l;
        @(posedge clk iff (in_valid && in_ready));
    endtask

    task automatic drain_and_set_depth(input logic [4:0] v);
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk iff (cfg_valid && cfg_ready));
        cfg_valid <= 0;
    endtask

    // kind 0 random, 1 no error, 2 zero weights, 3 full-scale error
    task automatic send_frame(input int len, input int kind);
        logic [15:0] w, r, o;
        for (int i = 0; i < len; i++)
        begin
            w = 16'($urandom());
            r = 16'($urandom());
            o = 16'($urandom());
            if ($urandom_range(7) == 0)
                o = r + 16'($urandom_range(3));
            if (kind == 1)
                o = r;
            if (kind == 2 || $urandom_range(15) == 0)
                w = 0;
            if (kind == 3)
            begin
                w = 16'hFFFF;
                r = 16'hFFFF;
                o = 0;
            end
            send_pixel(w, r, o, i == len - 1);
        end
    endtask

    task automatic random_frames(input int items);
        int sent, len, k;
        sent = 0;
        while (sent < items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(30, 1);
            k = $urandom_range(9);
            send_frame(len, (k == 0) ? 1 : (k == 1) ? 2 : (k == 2) ? 3 : 0);
            sent += len;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_pixel(16'd1, 16'd5, 16'd5, 1'b1);
        send_pixel(16'd0, 16'hFFFF, 16'd0, 1'b1);
        send_pixel(16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
        send_pixel(16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
        send_pixel(16'd3, 16'd10, 16'd7, 1'b1);
        drain_and_set_depth(5'd16);
        send_pixel(16'd1, 16'd1, 16'd0, 1'b1);
        send_pixel(16'hFFFF, 16'hAAAA, 16'h5555, 1'b1);
        send_frame(4, 1);
        drain_and_set_depth(5'd1);
        send_pixel(16'd1, 16'd200, 16'd0, 1'b1);
        send_pixel(16'd1, 16'd1, 16'd0, 1'b1);
        drain_and_set_depth(5'd0);
        send_pixel(16'd2, 16'd3, 16'd1, 1'b1);
        drain_and_set_depth(5'd31);
        send_pixel(16'd2, 16'd3, 16'd1, 1'b1);
        drain_and_set_depth(5'd17);
        send_pixel(16'd9, 16'h1234, 16'h4321, 1'b1);

        drain_and_set_depth(5'd8);
        send_idle = 0;
        recv_idle = 0;
        fork
            begin
                hold <= 1;
                repeat (3000) @(posedge clk);
                hold <= 0;
            end
        join_none
        random_frames(500);

        drain_and_set_depth(5'($urandom_range(16, 1)));
        send_idle = 78;
        recv_idle = 0;
        random_frames(500);

        drain_and_set_depth(5'($urandom_range(31)));
        send_idle = 0;
        recv_idle = 78;
        random_frames(500);

        drain_and_set_depth(5'($urandom_range(16, 1)));
        send_idle = 29;
        recv_idle = 29;
        random_frames(500);

        drain_and_set_depth(5'd16);
        send_idle = 0;
        recv_idle = 0;
        send_frame(40, 3);

        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("masked_weighted_psnr_test passed");
        else
            $display("masked_weighted_psnr_test failed");
        $finish;
    end
endmodule

### masked_weighted_psnr.f
src/mwp_pkg.sv
src/mwp_datapath.sv
src/mwp_ctrl.sv
src/masked_weighted_psnr.sv
src/mwp_checker.sv
tb/masked_weighted_psnr_checker.sv
tb/masked_weighted_psnr_test.sv
